FILE: hw/rtl/mcrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrb_pkg
// Shared types, address map, masks and RAM window tables for the
// memory-control register bank.
// ----------------------------------------------------------------------------
package mcrb_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned BaseW  = 24;
  localparam int unsigned CommonW = 16;
  localparam int unsigned WinW   = 3;
  localparam int unsigned NumBase  = 2;
  localparam int unsigned NumDelay = 6;

  // address map
  localparam logic [25:0]      BankPage      = 26'h07E0040; // 0x1F801000 >> 6
  localparam logic [3:0]       SlotFirstDly  = 4'd2;
  localparam logic [3:0]       SlotCommon    = 4'd8;
  localparam logic [AddrW-1:0] RamSizeAddr   = 32'h1F80_1060;
  localparam logic [AddrW-1:0] CacheCtrlAddr = 32'hFFFE_0130;

  // store and read-back masks
  localparam logic [7:0]       BaseReadTop   = 8'h1F;
  localparam logic [DataW-1:0] DelayStoreMask = 32'hEF1F_FFFF;
  localparam int unsigned      DelayErrBit   = 28;
  localparam logic [DataW-1:0] CacheReadMask = 32'hFFFF_FBBF;
  localparam int unsigned      WinLsb        = 9;
  localparam logic [DataW-1:0] NoneAddr      = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_BASE,
    SEL_DELAY,
    SEL_COMMON,
    SEL_RAM,
    SEL_CACHE
  } sel_e;

  // decoded register target
  typedef struct packed {
    sel_e       sel;
    logic [2:0] idx;
  } dec_t;

  function automatic logic [DataW-1:0] locked_start_f(input logic [WinW-1:0] win);
    logic [DataW-1:0] r;
    unique case (win)
      3'd0:    r = 32'h0010_0000;
      3'd1:    r = 32'h0040_0000;
      3'd2:    r = 32'h0020_0000;
      3'd4:    r = 32'h0020_0000;
      3'd6:    r = 32'h0040_0000;
      default: r = NoneAddr;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] hiz_first_f(input logic [WinW-1:0] win);
    logic [DataW-1:0] r;
    unique case (win)
      3'd2:    r = 32'h0010_0000;
      3'd3:    r = 32'h0040_0000;
      3'd6:    r = 32'h0020_0000;
      default: r = NoneAddr;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] hiz_last_f(input logic [WinW-1:0] win);
    logic [DataW-1:0] r;
    unique case (win)
      3'd2:    r = 32'h001F_FFFF;
      3'd3:    r = 32'h007F_FFFF;
      3'd6:    r = 32'h003F_FFFF;
      default: r = NoneAddr;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/mcrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrb_if
// Valid/ready channels of the memory-control register bank: access request
// and access response.
// ----------------------------------------------------------------------------
interface mcrb_req_if;
  logic                              valid;
  logic                              ready;
  mcrb_pkg::op_e                     operation;
  logic [mcrb_pkg::AddrW-1:0]        address;
  logic [mcrb_pkg::DataW-1:0]        write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface mcrb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mcrb_pkg::DataW-1:0]        read_data;
  logic                              hit;
  logic [mcrb_pkg::DataW-1:0]        locked_start;
  logic [mcrb_pkg::DataW-1:0]        hiz_first;
  logic [mcrb_pkg::DataW-1:0]        hiz_last;

  modport source (output valid, read_data, hit, locked_start, hiz_first, hiz_last,
                  input ready);
  modport sink   (input valid, read_data, hit, locked_start, hiz_first, hiz_last,
                  output ready);
endinterface

FILE: hw/rtl/mcrb_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrb_decode
// Address decoder: maps a bus address onto one of the eleven registers.
// ----------------------------------------------------------------------------
module mcrb_decode (
  input  logic [mcrb_pkg::AddrW-1:0] addr_i,
  output mcrb_pkg::dec_t             dec_o
);

  logic [3:0] slot;
  logic       bank_hit;

  // word slot inside the 64-byte timing bank
  assign slot     = addr_i[5:2];
  assign bank_hit = (addr_i[31:6] == mcrb_pkg::BankPage) && (addr_i[1:0] == 2'b00)
                    && (slot <= mcrb_pkg::SlotCommon);

  // register select
  always_comb begin
    dec_o.sel = mcrb_pkg::SEL_NONE;
    dec_o.idx = 3'd0;
    if (bank_hit) begin
      if (slot < mcrb_pkg::SlotFirstDly) begin
        dec_o.sel = mcrb_pkg::SEL_BASE;
        dec_o.idx = slot[2:0];
      end else if (slot < mcrb_pkg::SlotCommon) begin
        dec_o.sel = mcrb_pkg::SEL_DELAY;
        dec_o.idx = 3'(slot - mcrb_pkg::SlotFirstDly);
      end else begin
        dec_o.sel = mcrb_pkg::SEL_COMMON;
      end
    end else if (addr_i == mcrb_pkg::RamSizeAddr) begin
      dec_o.sel = mcrb_pkg::SEL_RAM;
    end else if (addr_i == mcrb_pkg::CacheCtrlAddr) begin
      dec_o.sel = mcrb_pkg::SEL_CACHE;
    end
  end

endmodule

FILE: hw/rtl/mcrb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrb_regs
// Register storage with write masks, error-flag clear and read-back mux.
// ----------------------------------------------------------------------------
module mcrb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  mcrb_pkg::dec_t                    dec_i,
  input  logic [mcrb_pkg::DataW-1:0]        wdata_i,
  output logic [mcrb_pkg::DataW-1:0]        rdata_o,
  output logic [mcrb_pkg::WinW-1:0]         win_o
);

  logic [mcrb_pkg::BaseW-1:0]   base_q  [mcrb_pkg::NumBase];
  logic [mcrb_pkg::BaseW-1:0]   base_d  [mcrb_pkg::NumBase];
  logic [mcrb_pkg::DataW-1:0]   delay_q [mcrb_pkg::NumDelay];
  logic [mcrb_pkg::DataW-1:0]   delay_d [mcrb_pkg::NumDelay];
  logic [mcrb_pkg::CommonW-1:0] common_q, common_d;
  logic [mcrb_pkg::DataW-1:0]   ram_q, ram_d;
  logic [mcrb_pkg::DataW-1:0]   cache_q, cache_d;
  logic [mcrb_pkg::DataW-1:0]   delay_old;
  logic                         err_keep;

  assign delay_old = delay_q[dec_i.idx];
  // error flag survives only a write of zero to it
  assign err_keep  = !wdata_i[mcrb_pkg::DelayErrBit] && delay_old[mcrb_pkg::DelayErrBit];

  // next-state for the addressed register
  always_comb begin
    base_d   = base_q;
    delay_d  = delay_q;
    common_d = common_q;
    ram_d    = ram_q;
    cache_d  = cache_q;
    if (wr_en_i) begin
      unique case (dec_i.sel)
        mcrb_pkg::SEL_BASE:   base_d[dec_i.idx[0]] = wdata_i[mcrb_pkg::BaseW-1:0];
        mcrb_pkg::SEL_DELAY: begin
          delay_d[dec_i.idx] = wdata_i & mcrb_pkg::DelayStoreMask;
          delay_d[dec_i.idx][mcrb_pkg::DelayErrBit] = err_keep;
        end
        mcrb_pkg::SEL_COMMON: common_d = wdata_i[mcrb_pkg::CommonW-1:0];
        mcrb_pkg::SEL_RAM:    ram_d    = wdata_i;
        mcrb_pkg::SEL_CACHE:  cache_d  = wdata_i;
        default: ;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcrb_pkg::NumBase; i++) base_q[i] <= '0;
      for (int i = 0; i < mcrb_pkg::NumDelay; i++) delay_q[i] <= '0;
      common_q <= '0;
      ram_q    <= '0;
      cache_q  <= '0;
    end else begin
      base_q   <= base_d;
      delay_q  <= delay_d;
      common_q <= common_d;
      ram_q    <= ram_d;
      cache_q  <= cache_d;
    end
  end

  // read-back mux, current contents
  always_comb begin
    unique case (dec_i.sel)
      mcrb_pkg::SEL_BASE:   rdata_o = {mcrb_pkg::BaseReadTop, base_q[dec_i.idx[0]]};
      mcrb_pkg::SEL_DELAY:  rdata_o = delay_old;
      mcrb_pkg::SEL_COMMON: rdata_o = {{(mcrb_pkg::DataW-mcrb_pkg::CommonW){1'b0}}, common_q};
      mcrb_pkg::SEL_RAM:    rdata_o = ram_q;
      mcrb_pkg::SEL_CACHE:  rdata_o = cache_q & mcrb_pkg::CacheReadMask;
      default:              rdata_o = '0;
    endcase
  end

  // window follows this beat's write to the RAM size register
  assign win_o = ram_d[mcrb_pkg::WinLsb +: mcrb_pkg::WinW];

endmodule

FILE: hw/rtl/memory_control_register_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_control_register_bank_core
// Memory-control register bank: one read or write access per beat, with the
// RAM window ranges reported on every response.
//
//   channel  dir  fields                                         handshake
//   req_i    in   operation, address, write_data                 valid/ready
//   rsp_o    out  read_data, hit, locked_start, hiz_first,       valid/ready
//                 hiz_last
//
// One beat per cycle sustained while responses are taken; the response
// follows acceptance via the input register, then decode/update into the result register.
// Registers are updated when the beat leaves the input register, in order.
// Reset clears all registers and both stage valids at once.
// A stalled response holds; the input register still drains into it once it
// is taken, so the request side stalls only when both stages are full.
// ----------------------------------------------------------------------------
module memory_control_register_bank_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcrb_req_if.sink      req_i,
  mcrb_rsp_if.source    rsp_o
);

  // input stage
  logic                         in_valid_q;
  mcrb_pkg::op_e                in_op_q;
  logic [mcrb_pkg::AddrW-1:0]   in_addr_q;
  logic [mcrb_pkg::DataW-1:0]   in_wdata_q;

  // result stage
  logic                         out_valid_q;
  logic [mcrb_pkg::DataW-1:0]   out_rdata_q, out_rdata_d;
  logic                         out_hit_q, out_hit_d;
  logic [mcrb_pkg::WinW-1:0]    out_win_q;

  logic                         advance;
  logic                         in_take;
  logic                         is_write;
  mcrb_pkg::dec_t               dec;
  logic [mcrb_pkg::DataW-1:0]   reg_rdata;
  logic [mcrb_pkg::WinW-1:0]    win_next;

  // stage flow
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_take     = req_i.valid && req_i.ready;
  assign is_write    = (in_op_q == mcrb_pkg::OP_WRITE);

  mcrb_decode u_decode (
    .addr_i (in_addr_q),
    .dec_o  (dec)
  );

  mcrb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (advance && is_write),
    .dec_i   (dec),
    .wdata_i (in_wdata_q),
    .rdata_o (reg_rdata),
    .win_o   (win_next)
  );

  // response payload
  assign out_hit_d   = (dec.sel != mcrb_pkg::SEL_NONE);
  assign out_rdata_d = is_write ? '0 : reg_rdata;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q    <= req_i.operation;
      in_addr_q  <= req_i.address;
      in_wdata_q <= req_i.write_data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rdata_q <= out_rdata_d;
      out_hit_q   <= out_hit_d;
      out_win_q   <= win_next;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = out_rdata_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.locked_start = mcrb_pkg::locked_start_f(out_win_q);
  assign rsp_o.hiz_first    = mcrb_pkg::hiz_first_f(out_win_q);
  assign rsp_o.hiz_last     = mcrb_pkg::hiz_last_f(out_win_q);

endmodule

FILE: hw/rtl/mcrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrb_checker
// Port-level checks on the memory-control register bank, bound to the top.
// ----------------------------------------------------------------------------
module mcrb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [mcrb_pkg::DataW-1:0]  rsp_rdata_i,
  input logic                        rsp_hit_i,
  input logic [mcrb_pkg::DataW-1:0]  rsp_locked_i,
  input logic [mcrb_pkg::DataW-1:0]  rsp_hiz_first_i,
  input logic [mcrb_pkg::DataW-1:0]  rsp_hiz_last_i
);

  // stalled response beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped while stalled");

  // stalled response beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_rdata_i) && $stable(rsp_hit_i)
      && $stable(rsp_locked_i) && $stable(rsp_hiz_first_i) && $stable(rsp_hiz_last_i))
    else $error("response payload changed while stalled");

  // a miss never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_rdata_i == '0)
    else $error("read data on an unmapped access");

  // high-impedance range is either fully present or fully absent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((rsp_hiz_first_i == mcrb_pkg::NoneAddr) ==
                     (rsp_hiz_last_i == mcrb_pkg::NoneAddr)))
    else $error("inconsistent high-impedance range");

  // a present high-impedance range runs upward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_hiz_first_i != mcrb_pkg::NoneAddr) |->
      rsp_hiz_first_i <= rsp_hiz_last_i)
    else $error("high-impedance range reversed");

endmodule

bind memory_control_register_bank_core mcrb_checker u_mcrb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_rdata_i     (rsp_o.read_data),
  .rsp_hit_i       (rsp_o.hit),
  .rsp_locked_i    (rsp_o.locked_start),
  .rsp_hiz_first_i (rsp_o.hiz_first),
  .rsp_hiz_last_i  (rsp_o.hiz_last)
);
